/* rtl/efe_pkg.sv */
// Shared types, register indexes and slot positions for the escaped frame encoder.
`timescale 1ns / 1ps

package efe_pkg;

    localparam int EFE_QUEUE_DEPTH = 2;
    localparam int EFE_CFG_DATA_W  = 64;
    localparam int EFE_CFG_INDEX_W = 3;
    localparam int EFE_NUM_SLOTS   = 6;

    // Configuration register indexes
    localparam logic [EFE_CFG_INDEX_W-1:0] CFG_CHECKSUM_EN = 3'd0;
    localparam logic [EFE_CFG_INDEX_W-1:0] CFG_LENGTH_EN   = 3'd1;
    localparam logic [EFE_CFG_INDEX_W-1:0] CFG_TERM_CHAR   = 3'd2;
    localparam logic [EFE_CFG_INDEX_W-1:0] CFG_ESC_CHAR    = 3'd3;
    localparam logic [EFE_CFG_INDEX_W-1:0] CFG_ESC_MASK_0  = 3'd4;
    localparam logic [EFE_CFG_INDEX_W-1:0] CFG_ESC_MASK_1  = 3'd5;
    localparam logic [EFE_CFG_INDEX_W-1:0] CFG_ESC_MASK_2  = 3'd6;
    localparam logic [EFE_CFG_INDEX_W-1:0] CFG_ESC_MASK_3  = 3'd7;

    // Output byte slots of one item, in emission order
    localparam int SLOT_ESC_LEN  = 0;
    localparam int SLOT_LEN      = 1;
    localparam int SLOT_ESC_DATA = 2;
    localparam int SLOT_DATA     = 3;
    localparam int SLOT_CK       = 4;
    localparam int SLOT_TERM     = 5;

    typedef struct packed {
        logic        checksum_en;
        logic        length_en;
        logic [7:0]  term_char;
        logic [7:0]  esc_char;
        logic [63:0] esc_mask_0;
        logic [63:0] esc_mask_1;
        logic [63:0] esc_mask_2;
        logic [63:0] esc_mask_3;
    } t_cfg;

    typedef struct packed {
        logic [EFE_NUM_SLOTS-1:0] slots;
        logic [7:0]               data_byte;
        logic [7:0]               len_byte;
        logic [7:0]               ck_byte;
        logic                     last;
    } t_desc;

endpackage

/* rtl/efe_front.sv */
// Front end: accepts input bytes, looks up escapes, keeps the running sum, builds descriptors.
`timescale 1ns / 1ps

module efe_front
    import efe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_first_byte,
    input  logic       i_last_byte,
    input  logic       i_raw_mode,
    input  logic [7:0] i_frame_length,
    input  logic       i_full,
    output logic       o_push,
    output t_desc      o_desc
);

    logic [7:0]   r_sum;
    logic [7:0]   n_sum;
    logic [255:0] mask_all;
    logic         with_len;
    logic         esc_len;
    logic         esc_data;
    logic [7:0]   sum_base;
    logic [7:0]   sum_len;

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

    assign mask_all = {i_cfg.esc_mask_3, i_cfg.esc_mask_2, i_cfg.esc_mask_1, i_cfg.esc_mask_0};
    assign esc_len  = mask_all[i_frame_length];
    assign esc_data = mask_all[i_data_byte];
    assign with_len = i_first_byte && i_cfg.length_en;

    // A first mark restarts the sum before the length byte
    assign sum_base = i_first_byte ? 8'd0 : r_sum;
    assign sum_len  = sum_base + (with_len ? i_frame_length : 8'd0);
    assign n_sum    = sum_len + i_data_byte;

    always_comb begin
        o_desc           = '0;
        o_desc.data_byte = i_data_byte;
        o_desc.len_byte  = i_frame_length;
        o_desc.ck_byte   = 8'd0 - n_sum;
        o_desc.last      = i_last_byte;
        o_desc.slots[SLOT_DATA] = 1'b1;
        if (!i_raw_mode) begin
            o_desc.slots[SLOT_ESC_LEN]  = with_len && esc_len;
            o_desc.slots[SLOT_LEN]      = with_len;
            o_desc.slots[SLOT_ESC_DATA] = esc_data;
            o_desc.slots[SLOT_CK]       = i_last_byte && i_cfg.checksum_en;
            o_desc.slots[SLOT_TERM]     = i_last_byte && (i_cfg.term_char != 8'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= 8'd0;
        end else if (o_push && !i_raw_mode) begin
            r_sum <= n_sum;
        end
    end

endmodule

/* rtl/efe_queue.sv */
// Short descriptor queue between the front and back ends.
`timescale 1ns / 1ps

module efe_queue
    import efe_pkg::*;
#(
    parameter int DEPTH = EFE_QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_push_desc,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_head_valid,
    output t_desc o_head_desc
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_desc            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head_desc  = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* rtl/efe_back.sv */
// Back end: walks the slots of the head descriptor and emits one byte per cycle while the output is not stalled.
`timescale 1ns / 1ps

module efe_back
    import efe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_head_valid,
    input  t_desc      i_head_desc,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_end_of_frame
);

    logic [EFE_NUM_SLOTS-1:0] r_sent;
    logic [EFE_NUM_SLOTS-1:0] n_sent;
    logic [EFE_NUM_SLOTS-1:0] remain;
    logic [EFE_NUM_SLOTS-1:0] pick;
    logic                     is_last;
    logic                     advance;
    logic [7:0]               sel_byte;
    logic                     r_out_valid;
    logic [7:0]               r_out_byte;
    logic                     r_last_of_run;
    logic                     r_end_of_frame;

    assign remain  = i_head_desc.slots & ~r_sent;
    assign pick    = remain & (~remain + 1'b1);
    assign is_last = ((remain & ~pick) == '0);
    assign advance = !r_out_valid || !i_out_stall;
    assign o_pop   = advance && i_head_valid && is_last;
    assign n_sent  = is_last ? '0 : (r_sent | pick);

    always_comb begin
        priority if (pick[SLOT_ESC_LEN] || pick[SLOT_ESC_DATA]) begin
            sel_byte = i_cfg.esc_char;
        end else if (pick[SLOT_LEN]) begin
            sel_byte = i_head_desc.len_byte;
        end else if (pick[SLOT_DATA]) begin
            sel_byte = i_head_desc.data_byte;
        end else if (pick[SLOT_CK]) begin
            sel_byte = i_head_desc.ck_byte;
        end else begin
            sel_byte = i_cfg.term_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sent      <= '0;
        end else if (advance) begin
            r_out_valid <= i_head_valid;
            if (i_head_valid) begin
                r_sent <= n_sent;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_head_valid) begin
            r_out_byte     <= sel_byte;
            r_last_of_run  <= is_last;
            r_end_of_frame <= is_last && i_head_desc.last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_last_of_run  = r_last_of_run;
    assign o_end_of_frame = r_end_of_frame;

    a_sent_within_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> ((r_sent & ~i_head_desc.slots) == '0))
        else $error("sent slots not part of head descriptor");

    a_sent_clear_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_head_valid |-> (r_sent == '0))
        else $error("slot progress left over with empty queue");

    a_data_slot_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> i_head_desc.slots[SLOT_DATA])
        else $error("descriptor without data slot");

    a_eof_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_end_of_frame |-> r_last_of_run)
        else $error("end of frame on a byte that does not end its run");

endmodule

/* rtl/escaped_frame_encoder.sv */
// Top level of the escaped frame encoder: configuration registers and front/queue/back.
// An accepted item is written into the descriptor queue; its bytes then go out through the output register.
// The single output register gives one output byte per cycle while the output is not stalled;
//   an item makes 1 to 6 output bytes, and input is taken every cycle while the descriptor queue
//   has room, so a stream of escaped bytes is paced by the output.
// Reset (synchronous, active low) clears configuration, running sum, queue and output valid.
`timescale 1ns / 1ps

module escaped_frame_encoder
    import efe_pkg::*;
#(
    parameter int QUEUE_DEPTH = EFE_QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [EFE_CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [EFE_CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [7:0]                 i_data_byte,
    input  logic                       i_first_byte,
    input  logic                       i_last_byte,
    input  logic                       i_raw_mode,
    input  logic [7:0]                 i_frame_length,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [7:0]                 o_out_byte,
    output logic                       o_last_of_run,
    output logic                       o_end_of_frame
);

    t_cfg  r_cfg;
    logic  full;
    logic  push;
    t_desc push_desc;
    logic  pop;
    logic  head_valid;
    t_desc head_desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_CHECKSUM_EN: r_cfg.checksum_en <= i_cfg_data[0];
                CFG_LENGTH_EN:   r_cfg.length_en   <= i_cfg_data[0];
                CFG_TERM_CHAR:   r_cfg.term_char   <= i_cfg_data[7:0];
                CFG_ESC_CHAR:    r_cfg.esc_char    <= i_cfg_data[7:0];
                CFG_ESC_MASK_0:  r_cfg.esc_mask_0  <= i_cfg_data[63:0];
                CFG_ESC_MASK_1:  r_cfg.esc_mask_1  <= i_cfg_data[63:0];
                CFG_ESC_MASK_2:  r_cfg.esc_mask_2  <= i_cfg_data[63:0];
                CFG_ESC_MASK_3:  r_cfg.esc_mask_3  <= i_cfg_data[63:0];
            endcase
        end
    end

    efe_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_first_byte   (i_first_byte),
        .i_last_byte    (i_last_byte),
        .i_raw_mode     (i_raw_mode),
        .i_frame_length (i_frame_length),
        .i_full         (full),
        .o_push         (push),
        .o_desc         (push_desc)
    );

    efe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_desc  (push_desc),
        .i_pop        (pop),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head_desc  (head_desc)
    );

    efe_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_head_valid   (head_valid),
        .i_head_desc    (head_desc),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_last_of_run  (o_last_of_run),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the escaped frame encoder: directed table, then random frames.
`timescale 1ns / 1ps

module tb_top;
    import efe_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       end_of_frame;
    } t_enc_byte;

    // One row of the directed table: a register write or an input byte.
    // Golden bytes are written left to right in emission order; n_gold = 0 means predict.
    typedef struct packed {
        logic                       is_reg;
        logic [EFE_CFG_INDEX_W-1:0] reg_idx;
        logic [EFE_CFG_DATA_W-1:0]  reg_val;
        logic [7:0]                 data;
        logic                       first;
        logic                       last;
        logic                       raw;
        logic [7:0]                 len;
        logic [2:0]                 n_gold;
        logic [47:0]                gold;
    } t_plan_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_wr_en;
    logic [EFE_CFG_INDEX_W-1:0] i_cfg_index;
    logic [EFE_CFG_DATA_W-1:0]  i_cfg_data;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic [7:0]                 i_data_byte;
    logic                       i_first_byte;
    logic                       i_last_byte;
    logic                       i_raw_mode;
    logic [7:0]                 i_frame_length;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic [7:0]                 o_out_byte;
    logic                       o_last_of_run;
    logic                       o_end_of_frame;

    // Predictor copy of the configuration and the running sum
    logic        cfg_checksum_en;
    logic        cfg_length_en;
    logic [7:0]  cfg_term;
    logic [7:0]  cfg_esc;
    logic [63:0] cfg_mask [4];
    logic [7:0]  frame_sum;

    logic [7:0]  item_bytes [$];
    t_enc_byte   pending_bytes [$];
    t_plan_row   directed_plan [$];

    int mismatch_count = 0;
    int tx_idle_pct    = 0;
    int rx_stall_pct   = 0;
    int rx_hold_left   = 0;

    escaped_frame_encoder i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_first_byte   (i_first_byte),
        .i_last_byte    (i_last_byte),
        .i_raw_mode     (i_raw_mode),
        .i_frame_length (i_frame_length),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_last_of_run  (o_last_of_run),
        .o_end_of_frame (o_end_of_frame)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("tb: mismatch at %0t ns: %s", $time, what);
    endtask

    function automatic void stuff_byte(input logic [7:0] v);
        frame_sum = frame_sum + v;
        if (cfg_mask[v[7:6]][v[5:0]])
            item_bytes = {item_bytes, cfg_esc};
        item_bytes = {item_bytes, v};
    endfunction

    // Bytes that one input transfer makes, in order; updates the running sum
    function automatic void encode_item(input logic [7:0] data, input logic first,
                                        input logic last, input logic raw,
                                        input logic [7:0] len);
        item_bytes.delete();
        if (raw) begin
            item_bytes = {item_bytes, data};
        end else begin
            if (first) begin
                frame_sum = 8'd0;
                if (cfg_length_en)
                    stuff_byte(len);
            end
            stuff_byte(data);
            if (last) begin
                if (cfg_checksum_en)
                    item_bytes = {item_bytes, 8'(8'd0 - frame_sum)};
                if (cfg_term != 8'd0)
                    item_bytes = {item_bytes, cfg_term};
            end
        end
    endfunction

    function automatic t_plan_row byte_row(input logic [7:0] data, input logic first,
                                           input logic last, input logic raw,
                                           input logic [7:0] len, input int n_gold = 0,
                                           input logic [47:0] gold = '0);
        t_plan_row row;
        row        = '0;
        row.data   = data;
        row.first  = first;
        row.last   = last;
        row.raw    = raw;
        row.len    = len;
        row.n_gold = n_gold[2:0];
        row.gold   = gold;
        return row;
    endfunction

    function automatic t_plan_row reg_row(input logic [EFE_CFG_INDEX_W-1:0] idx,
                                          input logic [EFE_CFG_DATA_W-1:0] val);
        t_plan_row row;
        row         = '0;
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    task automatic write_reg(input logic [EFE_CFG_INDEX_W-1:0] idx,
                             input logic [EFE_CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_CHECKSUM_EN: cfg_checksum_en = val[0];
            CFG_LENGTH_EN:   cfg_length_en   = val[0];
            CFG_TERM_CHAR:   cfg_term        = val[7:0];
            CFG_ESC_CHAR:    cfg_esc         = val[7:0];
            CFG_ESC_MASK_0:  cfg_mask[0]     = val;
            CFG_ESC_MASK_1:  cfg_mask[1]     = val;
            CFG_ESC_MASK_2:  cfg_mask[2]     = val;
            CFG_ESC_MASK_3:  cfg_mask[3]     = val;
            default: ;
        endcase
    endtask

    // Hold the input off until every expected byte is out, then let the pipe go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_bytes.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic offer_item(input logic [7:0] data, input logic first, input logic last,
                              input logic raw, input logic [7:0] len, input int n_gold = 0,
                              input logic [47:0] gold = '0);
        int        n;
        t_enc_byte b;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_data_byte    <= data;
        i_first_byte   <= first;
        i_last_byte    <= last;
        i_raw_mode     <= raw;
        i_frame_length <= len;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0)
            @(posedge i_clk);
        // transfer taken at this edge
        encode_item(data, first, last, raw, len);
        if (n_gold != 0) begin
            item_bytes.delete();
            for (int k = 0; k < n_gold; k++)
                item_bytes = {item_bytes, gold[47 - 8 * k -: 8]};
        end
        n = item_bytes.size();
        for (int k = 0; k < n; k++) begin
            b = '{item_bytes[k], k == n - 1, last && (k == n - 1)};
            pending_bytes = {pending_bytes, b};
        end
    endtask

    task automatic setup_phase(input int phase);
        logic [63:0] m [4];
        logic [63:0] ck;
        logic [63:0] ln;
        logic [63:0] term;
        logic [63:0] esc;
        for (int i = 0; i < 4; i++)
            m[i] = {$urandom, $urandom};
        ck   = {$urandom, $urandom};
        ln   = {$urandom, $urandom};
        term = {$urandom, $urandom};
        esc  = {$urandom, $urandom};
        case (phase)
            0: begin
                m = '{default: '1};
                ck = 64'd1; ln = 64'd1; term = 64'hFF; esc = 64'hFF;
            end
            1: begin
                m = '{default: '0};
                ck = 64'd0; ln = 64'd0; term = 64'd0; esc = 64'd0;
            end
            2: begin
                ck = 64'd1; ln = 64'd0;
            end
            3: begin
                m = '{64'h0, 64'h6000_0000_0000_0000, 64'h0, 64'h0};
                ck = 64'd1; ln = 64'd1; term = 64'h7E; esc = 64'h7D;
            end
            4: begin
                ck = 64'd0; ln = 64'd1; term = 64'd0;
            end
            6: begin
                m = '{default: 64'h5555_5555_5555_5555};
                ck = 64'd1; ln = 64'd1; term = 64'h01; esc = 64'h00;
            end
            default: ;
        endcase
        write_reg(CFG_CHECKSUM_EN, ck);
        write_reg(CFG_LENGTH_EN, ln);
        write_reg(CFG_TERM_CHAR, term);
        write_reg(CFG_ESC_CHAR, esc);
        write_reg(CFG_ESC_MASK_0, m[0]);
        write_reg(CFG_ESC_MASK_1, m[1]);
        write_reg(CFG_ESC_MASK_2, m[2]);
        write_reg(CFG_ESC_MASK_3, m[3]);
    endtask

    task automatic run_phase(input int phase, input int count);
        int         sent;
        int         kind;
        int         frame_len;
        logic       drop_first;
        logic       drop_last;
        logic       pressed;
        logic [7:0] value;
        sent    = 0;
        pressed = 1'b0;
        while (sent < count) begin
            kind = $urandom_range(9);
            if (kind == 0) begin
                offer_item(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                           8'($urandom));
                sent++;
            end else begin
                frame_len  = ($urandom_range(15) == 0) ? $urandom_range(8, 20)
                                                       : $urandom_range(1, 5);
                drop_first = (kind == 1) && ($urandom_range(1) == 1);
                drop_last  = (kind == 1) && !drop_first;
                for (int k = 0; k < frame_len; k++) begin
                    case ($urandom_range(7))
                        0:       value = cfg_esc;
                        1:       value = cfg_term;
                        2:       value = 8'h00;
                        3:       value = 8'hFF;
                        default: value = 8'($urandom);
                    endcase
                    // kind 2 restarts the frame halfway with a second first mark
                    offer_item(value,
                               (k == 0 && !drop_first) || (kind == 2 && k == frame_len / 2),
                               k == frame_len - 1 && !drop_last,
                               $urandom_range(19) == 0,
                               ($urandom_range(7) == 0) ? 8'($urandom) : 8'(frame_len));
                    sent++;
                    if (phase == 2 && sent >= 10 && !pressed) begin
                        rx_hold_left = 80;
                        pressed = 1'b1;
                    end
                    if (phase == 3 && sent >= 15 && !pressed) begin
                        settle();
                        pressed = 1'b1;
                    end
                end
            end
        end
    endtask

    // Receiver: random stall, or a long hold-off when one is requested
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_left > 0) begin
                i_out_stall <= 1'b1;
                rx_hold_left--;
            end else begin
                i_out_stall <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_output
        t_enc_byte want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h", o_out_byte));
            end else begin
                want = pending_bytes.pop_front();
                if (o_out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              o_out_byte, want.out_byte));
                if (o_last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run %b, want %b",
                                              o_last_of_run, want.last_of_run));
                if (o_end_of_frame !== want.end_of_frame)
                    report_mismatch($sformatf("end_of_frame %b, want %b",
                                              o_end_of_frame, want.end_of_frame));
            end
        end
    end

    initial begin
        cfg_checksum_en = 1'b0;
        cfg_length_en   = 1'b0;
        cfg_term        = 8'd0;
        cfg_esc         = 8'd0;
        cfg_mask        = '{default: '0};
        frame_sum       = 8'd0;

        i_rst_n        <= 1'b0;
        i_cfg_wr_en    <= 1'b0;
        i_cfg_index    <= CFG_CHECKSUM_EN;
        i_cfg_data     <= '0;
        i_in_valid     <= 1'b0;
        i_data_byte    <= 8'd0;
        i_first_byte   <= 1'b0;
        i_last_byte    <= 1'b0;
        i_raw_mode     <= 1'b0;
        i_frame_length <= 8'd0;

        // Reset configuration: no framing bytes, nothing escaped
        directed_plan = {directed_plan,
            byte_row(8'h00, 1'b0, 1'b0, 1'b1, 8'h00, 1, 48'h00_0000000000)};
        directed_plan = {directed_plan,
            byte_row(8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF, 1, 48'hFF_0000000000)};
        directed_plan = {directed_plan,
            byte_row(8'hFF, 1'b1, 1'b1, 1'b0, 8'hFF, 1, 48'hFF_0000000000)};
        directed_plan = {directed_plan,
            byte_row(8'h00, 1'b1, 1'b1, 1'b0, 8'h00, 1, 48'h00_0000000000)};
        // Full framing: 0x00, 0x7D, 0x7E, 0x80 and 0xFF escaped with 0x7D, 0x7E terminator
        directed_plan = {directed_plan, reg_row(CFG_CHECKSUM_EN, 64'd1)};
        directed_plan = {directed_plan, reg_row(CFG_LENGTH_EN, 64'd1)};
        directed_plan = {directed_plan, reg_row(CFG_TERM_CHAR, 64'h7E)};
        directed_plan = {directed_plan, reg_row(CFG_ESC_CHAR, 64'h7D)};
        directed_plan = {directed_plan, reg_row(CFG_ESC_MASK_0, 64'h1)};
        directed_plan = {directed_plan, reg_row(CFG_ESC_MASK_1, 64'h6000_0000_0000_0000)};
        directed_plan = {directed_plan, reg_row(CFG_ESC_MASK_2, 64'h1)};
        directed_plan = {directed_plan, reg_row(CFG_ESC_MASK_3, 64'h8000_0000_0000_0000)};
        directed_plan = {directed_plan,
            byte_row(8'h7E, 1'b1, 1'b1, 1'b0, 8'h01, 5, 48'h01_7D_7E_81_7E_00)};
        directed_plan = {directed_plan,
            byte_row(8'h7D, 1'b1, 1'b1, 1'b0, 8'hFF, 6, 48'h7D_FF_7D_7D_84_7E)};
        // checksum of zero matches an escaped value but goes out bare
        directed_plan = {directed_plan,
            byte_row(8'h00, 1'b1, 1'b1, 1'b0, 8'h00, 6, 48'h7D_00_7D_00_00_7E)};
        // multi-byte frame with a raw byte in the middle
        directed_plan = {directed_plan, byte_row(8'h41, 1'b1, 1'b0, 1'b0, 8'h04)};
        directed_plan = {directed_plan, byte_row(8'h7E, 1'b0, 1'b0, 1'b0, 8'h04)};
        directed_plan = {directed_plan, byte_row(8'h55, 1'b0, 1'b0, 1'b1, 8'h04)};
        directed_plan = {directed_plan, byte_row(8'h80, 1'b0, 1'b0, 1'b0, 8'h04)};
        directed_plan = {directed_plan, byte_row(8'h10, 1'b0, 1'b1, 1'b0, 8'h04)};
        // restart with a second first mark
        directed_plan = {directed_plan, byte_row(8'h20, 1'b1, 1'b0, 1'b0, 8'h03)};
        directed_plan = {directed_plan, byte_row(8'h30, 1'b1, 1'b0, 1'b0, 8'h02)};
        directed_plan = {directed_plan, byte_row(8'hFE, 1'b0, 1'b1, 1'b0, 8'h02)};
        // bytes with no first mark continue the old sum
        directed_plan = {directed_plan, byte_row(8'h11, 1'b0, 1'b1, 1'b0, 8'h00)};
        directed_plan = {directed_plan, byte_row(8'h22, 1'b0, 1'b0, 1'b0, 8'hFF)};
        directed_plan = {directed_plan, byte_row(8'h33, 1'b0, 1'b1, 1'b0, 8'hFF)};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[r]) begin
            if (directed_plan[r].is_reg) begin
                settle();
                write_reg(directed_plan[r].reg_idx, directed_plan[r].reg_val);
            end else begin
                offer_item(directed_plan[r].data, directed_plan[r].first,
                           directed_plan[r].last, directed_plan[r].raw,
                           directed_plan[r].len, directed_plan[r].n_gold,
                           directed_plan[r].gold);
            end
        end

        for (int phase = 0; phase < 8; phase++) begin
            settle();
            tx_idle_pct  = 0;
            rx_stall_pct = 0;
            setup_phase(phase);
            case (phase % 4)
                1: tx_idle_pct = 46;
                2: rx_stall_pct = 46;
                3: begin
                    tx_idle_pct  = 10;
                    rx_stall_pct = 10;
                end
                default: ;
            endcase
            run_phase(phase, 39);
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_bytes.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
